@@ design/adll_pkg.sv @@
// ----------------------------------------------------------------------------
// adll_pkg: shared types and codes for the array doubly linked list core
// Slot geometry, operation, status and command codes, and the controller
// to datapath status bundle.
// ----------------------------------------------------------------------------
package adll_pkg;

  localparam int SLOTS   = 32;
  localparam int SLOT_W  = 5;
  localparam int LINK_W  = 6;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 6;
  localparam int STEP_W  = 7;

  // A link equal to the slot count means "no neighbor".
  localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(SLOTS);

  typedef logic [2:0]         mode_t;
  typedef logic [1:0]         status_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [LINK_W-1:0]  link_t;
  typedef logic [DATA_W-1:0]  data_t;
  typedef logic [COUNT_W-1:0] count_t;

  // Operation codes.
  localparam mode_t M_APPEND   = 3'd0;
  localparam mode_t M_PREPEND  = 3'd1;
  localparam mode_t M_INSERT   = 3'd2;
  localparam mode_t M_ERASE    = 3'd3;
  localparam mode_t M_ADVANCE  = 3'd4;
  localparam mode_t M_SIZE     = 3'd5;
  localparam mode_t M_CLEAR    = 3'd6;

  // Result status codes.
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_BAD_REF  = 2'd2;
  localparam status_t ST_WALK_OFF = 2'd3;

  // Datapath commands issued by the controller, one per cycle.
  typedef logic [3:0] adll_cmd_t;
  localparam adll_cmd_t C_NOP       = 4'd0;
  localparam adll_cmd_t C_LOAD      = 4'd1;
  localparam adll_cmd_t C_ALLOC     = 4'd2;
  localparam adll_cmd_t C_LINK      = 4'd3;
  localparam adll_cmd_t C_UNLINK    = 4'd4;
  localparam adll_cmd_t C_ERASE_FIN = 4'd5;
  localparam adll_cmd_t C_WALK      = 4'd6;
  localparam adll_cmd_t C_ADV_FIN   = 4'd7;
  localparam adll_cmd_t C_FULL      = 4'd8;
  localparam adll_cmd_t C_BAD_REF   = 4'd9;
  localparam adll_cmd_t C_WALK_OFF  = 4'd10;
  localparam adll_cmd_t C_SIZE      = 4'd11;
  localparam adll_cmd_t C_CLEAR     = 4'd12;

  typedef struct packed {
    mode_t mode;
    logic  full;
    logic  ref_ok;
    logic  link_none;
    logic  steps_zero;
    logic  out_free;
  } adll_stat_t;

endpackage

@@ design/adll_if.sv @@
// ----------------------------------------------------------------------------
// adll_if: valid/ready channels of the array doubly linked list core
// One interface for the operation channel and one for the result channel.
// ----------------------------------------------------------------------------
interface adll_in_if import adll_pkg::*; ();
  logic              valid;
  logic              ready;
  mode_t             mode;
  data_t             payload;
  slot_t             ref_slot;
  logic signed [6:0] step;

  modport source (output valid, output mode, output payload, output ref_slot,
                  output step, input ready);
  modport sink   (input valid, input mode, input payload, input ref_slot,
                  input step, output ready);
endinterface

interface adll_out_if import adll_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  logic    slot_valid;
  slot_t   result_slot;
  data_t   payload_out;
  count_t  entry_count;

  modport source (output valid, output status, output slot_valid,
                  output result_slot, output payload_out, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input slot_valid,
                  input result_slot, input payload_out, input entry_count,
                  output ready);
endinterface

@@ design/adll_ctrl.sv @@
// ----------------------------------------------------------------------------
// adll_ctrl: operation sequencer
// Takes one operation at a time and steps the datapath through it.
// ----------------------------------------------------------------------------
module adll_ctrl import adll_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  adll_stat_t stat,
  output adll_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_LINK  = 3'd2;
  localparam logic [2:0] S_ERFIN = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = C_NOP;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = C_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.mode) inside
          M_APPEND, M_PREPEND, M_INSERT: begin
            if (stat.mode == M_INSERT && !stat.ref_ok) begin
              if (stat.out_free) begin
                cmd       = C_BAD_REF;
                state_nxt = S_IDLE;
              end
            end else if (stat.full) begin
              if (stat.out_free) begin
                cmd       = C_FULL;
                state_nxt = S_IDLE;
              end
            end else begin
              cmd       = C_ALLOC;
              state_nxt = S_LINK;
            end
          end
          M_ERASE: begin
            if (!stat.ref_ok) begin
              if (stat.out_free) begin
                cmd       = C_BAD_REF;
                state_nxt = S_IDLE;
              end
            end else begin
              cmd       = C_UNLINK;
              state_nxt = S_ERFIN;
            end
          end
          M_ADVANCE: begin
            if (!stat.ref_ok) begin
              if (stat.out_free) begin
                cmd       = C_BAD_REF;
                state_nxt = S_IDLE;
              end
            end else begin
              state_nxt = S_WALK;
            end
          end
          M_CLEAR: begin
            if (stat.out_free) begin
              cmd       = C_CLEAR;
              state_nxt = S_IDLE;
            end
          end
          default: begin
            // Size and the unused code both just report the count.
            if (stat.out_free) begin
              cmd       = C_SIZE;
              state_nxt = S_IDLE;
            end
          end
        endcase
      end
      S_LINK: begin
        if (stat.out_free) begin
          cmd       = C_LINK;
          state_nxt = S_IDLE;
        end
      end
      S_ERFIN: begin
        if (stat.out_free) begin
          cmd       = C_ERASE_FIN;
          state_nxt = S_IDLE;
        end
      end
      S_WALK: begin
        if (stat.steps_zero) begin
          if (stat.out_free) begin
            cmd       = C_ADV_FIN;
            state_nxt = S_IDLE;
          end
        end else if (stat.link_none) begin
          if (stat.out_free) begin
            cmd       = C_WALK_OFF;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd = C_WALK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ design/adll_dpath.sv @@
// ----------------------------------------------------------------------------
// adll_dpath: slot store, free map, list ends and result register
// Executes one controller command per cycle.
// ----------------------------------------------------------------------------
module adll_dpath import adll_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  adll_cmd_t         cmd,
  output adll_stat_t        stat,
  input  mode_t             in_mode,
  input  data_t             in_payload,
  input  slot_t             in_ref_slot,
  input  logic signed [6:0] in_step,
  output logic              out_valid,
  input  logic              out_ready,
  output status_t           out_status,
  output logic              out_slot_valid,
  output slot_t             out_result_slot,
  output data_t             out_payload_out,
  output count_t            out_entry_count
);

  // Slot store: one write and one read port each, read data registered.
  data_t pay_mem  [SLOTS];
  link_t next_mem [SLOTS];
  link_t prev_mem [SLOTS];

  data_t rd_pay_r;
  link_t rd_next_r, rd_prev_r;

  logic [SLOTS-1:0] free_r;
  link_t            head_r, tail_r;
  count_t           count_r;

  mode_t             mode_r;
  data_t             data_r;
  slot_t             ref_r;
  logic [STEP_W-1:0] steps_r;
  logic              dir_r;
  slot_t             new_r;
  link_t             p_r;
  link_t             cur_r;

  logic    out_valid_r;
  status_t out_status_r;
  logic    out_slot_valid_r;
  slot_t   out_slot_r;
  data_t   out_payload_r;
  count_t  out_count_r;

  slot_t free_idx;
  link_t walk_link;
  link_t erase_sel;
  logic  out_free;

  logic  rd_en;
  slot_t rd_addr;
  logic  pay_we;
  logic  next_we, prev_we;
  slot_t next_wa, prev_wa;
  link_t next_wd, prev_wd;

  logic    res_we;
  status_t res_status;
  logic    res_valid;
  slot_t   res_slot;
  data_t   res_payload;
  count_t  res_count;

  logic [STEP_W-1:0] step_mag;

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (free_r[k]) free_idx = SLOT_W'(k);
    end
  end

  assign walk_link = dir_r ? rd_next_r : rd_prev_r;
  assign erase_sel = (rd_next_r != NONE_LINK) ? rd_next_r : rd_prev_r;
  assign out_free  = !out_valid_r || out_ready;
  assign step_mag  = in_step[6] ? (~in_step + 7'sd1) : in_step;

  assign stat.mode       = mode_r;
  assign stat.full       = ~|free_r;
  assign stat.ref_ok     = ~free_r[ref_r];
  assign stat.link_none  = (walk_link >= NONE_LINK);
  assign stat.steps_zero = (steps_r == '0);
  assign stat.out_free   = out_free;

  // Memory port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = in_ref_slot;
    pay_we  = 1'b0;
    next_we = 1'b0;
    prev_we = 1'b0;
    next_wa = free_idx;
    prev_wa = free_idx;
    next_wd = NONE_LINK;
    prev_wd = NONE_LINK;
    unique case (cmd)
      C_LOAD: begin
        rd_en = 1'b1;
      end
      C_ALLOC: begin
        pay_we  = 1'b1;
        next_we = 1'b1;
        prev_we = 1'b1;
        case (mode_r)
          M_APPEND: begin
            next_wd = NONE_LINK;
            prev_wd = tail_r;
          end
          M_PREPEND: begin
            next_wd = head_r;
            prev_wd = NONE_LINK;
          end
          default: begin
            next_wd = {1'b0, ref_r};
            prev_wd = rd_prev_r;
          end
        endcase
      end
      C_LINK: begin
        case (mode_r)
          M_APPEND: begin
            next_we = (tail_r != NONE_LINK);
            next_wa = tail_r[SLOT_W-1:0];
            next_wd = {1'b0, new_r};
          end
          M_PREPEND: begin
            prev_we = (head_r != NONE_LINK);
            prev_wa = head_r[SLOT_W-1:0];
            prev_wd = {1'b0, new_r};
          end
          default: begin
            prev_we = 1'b1;
            prev_wa = ref_r;
            prev_wd = {1'b0, new_r};
            next_we = (p_r != NONE_LINK);
            next_wa = p_r[SLOT_W-1:0];
            next_wd = {1'b0, new_r};
          end
        endcase
      end
      C_UNLINK: begin
        next_we = (rd_prev_r != NONE_LINK);
        next_wa = rd_prev_r[SLOT_W-1:0];
        next_wd = rd_next_r;
        prev_we = (rd_next_r != NONE_LINK);
        prev_wa = rd_next_r[SLOT_W-1:0];
        prev_wd = rd_prev_r;
        rd_en   = 1'b1;
        rd_addr = erase_sel[SLOT_W-1:0];
      end
      C_WALK: begin
        rd_en   = 1'b1;
        rd_addr = walk_link[SLOT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pay_we) pay_mem[free_idx] <= data_r;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (rd_en) begin
      rd_pay_r  <= pay_mem[rd_addr];
      rd_next_r <= next_mem[rd_addr];
      rd_prev_r <= prev_mem[rd_addr];
    end
  end

  // Result decode for the commands that finish an operation.
  always_comb begin
    res_we      = 1'b1;
    res_status  = ST_OK;
    res_valid   = 1'b0;
    res_slot    = '0;
    res_payload = '0;
    res_count   = count_r;
    unique case (cmd)
      C_LINK: begin
        res_valid   = 1'b1;
        res_slot    = new_r;
        res_payload = data_r;
        res_count   = count_r + 1'b1;
      end
      C_ERASE_FIN: begin
        if (cur_r != NONE_LINK) begin
          res_valid   = 1'b1;
          res_slot    = cur_r[SLOT_W-1:0];
          res_payload = rd_pay_r;
        end
      end
      C_ADV_FIN: begin
        res_valid   = 1'b1;
        res_slot    = cur_r[SLOT_W-1:0];
        res_payload = rd_pay_r;
      end
      C_FULL:     res_status = ST_FULL;
      C_BAD_REF:  res_status = ST_BAD_REF;
      C_WALK_OFF: res_status = ST_WALK_OFF;
      C_SIZE:     res_status = ST_OK;
      C_CLEAR:    res_count  = '0;
      default:    res_we     = 1'b0;
    endcase
  end

  // Operation registers and list ends.
  always_ff @(posedge clk) begin
    case (cmd)
      C_LOAD: begin
        mode_r  <= in_mode;
        data_r  <= in_payload;
        ref_r   <= in_ref_slot;
        steps_r <= step_mag;
        dir_r   <= ~in_step[6];
        cur_r   <= {1'b0, in_ref_slot};
      end
      C_ALLOC: begin
        new_r <= free_idx;
        p_r   <= rd_prev_r;
      end
      C_UNLINK: begin
        cur_r <= erase_sel;
      end
      C_WALK: begin
        cur_r   <= walk_link;
        steps_r <= steps_r - 1'b1;
      end
      default: begin
      end
    endcase
    if (res_we) begin
      out_status_r     <= res_status;
      out_slot_valid_r <= res_valid;
      out_slot_r       <= res_slot;
      out_payload_r    <= res_payload;
      out_count_r      <= res_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r      <= '1;
      head_r      <= NONE_LINK;
      tail_r      <= NONE_LINK;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_we) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd)
        C_ALLOC: begin
          free_r[free_idx] <= 1'b0;
        end
        C_LINK: begin
          count_r <= count_r + 1'b1;
          case (mode_r)
            M_APPEND: begin
              if (tail_r == NONE_LINK) head_r <= {1'b0, new_r};
              tail_r <= {1'b0, new_r};
            end
            M_PREPEND: begin
              if (head_r == NONE_LINK) tail_r <= {1'b0, new_r};
              head_r <= {1'b0, new_r};
            end
            default: begin
              if (p_r == NONE_LINK) head_r <= {1'b0, new_r};
            end
          endcase
        end
        C_UNLINK: begin
          if (rd_prev_r == NONE_LINK) head_r <= rd_next_r;
          if (rd_next_r == NONE_LINK) tail_r <= rd_prev_r;
          free_r[ref_r] <= 1'b1;
          if (count_r != '0) count_r <= count_r - 1'b1;
        end
        C_CLEAR: begin
          free_r  <= '1;
          head_r  <= NONE_LINK;
          tail_r  <= NONE_LINK;
          count_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot_valid  = out_slot_valid_r;
  assign out_result_slot = out_slot_r;
  assign out_payload_out = out_payload_r;
  assign out_entry_count = out_count_r;

  // Between operations every slot is either free or on the list.
  a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == C_LOAD) |-> ($countones(free_r) + int'(count_r) == SLOTS))
    else $error("free map and link count disagree");

  // Between operations the list ends are empty exactly when the count is zero.
  a_ends_match_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == C_LOAD) |-> (((head_r == NONE_LINK) == (count_r == '0)) &&
                         ((tail_r == NONE_LINK) == (count_r == '0))))
    else $error("list ends inconsistent with link count");

  // A result is only written when the output register can take it.
  a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_we |-> out_free)
    else $error("result written over a pending transfer");

  // A walk step never follows a missing link or runs past the step count.
  a_walk_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == C_WALK) |-> (!stat.steps_zero && !stat.link_none))
    else $error("illegal walk step");

  // Allocation only happens with a free slot.
  a_alloc_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == C_ALLOC) |-> (free_r != '0))
    else $error("allocation from a full store");

endmodule

@@ design/array_doubly_linked_list_core.sv @@
// One operation at a time; the next transfer can be taken once the previous
// result is registered. Every link walk step goes through the single read
// port of the slot store.
// Reset (synchronous, active low): empty list, every slot free, no result.
// ----------------------------------------------------------------------------
// array_doubly_linked_list_core: doubly linked list in a fixed slot store
// A controller sequences each operation through a datapath that holds the
// slot payloads, next and previous links, the free map and the list ends.
// ----------------------------------------------------------------------------
module array_doubly_linked_list_core import adll_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  adll_in_if.sink    in_chan,
  adll_out_if.source out_chan
);

  // The controller and the datapath talk only through one command code per
  // cycle and a small status bundle coming back.
  adll_cmd_t  cmd;
  adll_stat_t stat;

  // The sequencer owns the input ready: one operation is in flight at a
  // time, and a new transfer is taken as soon as the previous operation has
  // placed its result in the output register, even if that result has not
  // yet been taken downstream.
  adll_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath captures the operation on the transfer cycle, reads the
  // reference slot's links at the same time, and holds the result register
  // that drives the output channel.
  adll_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_mode         (in_chan.mode),
    .in_payload      (in_chan.payload),
    .in_ref_slot     (in_chan.ref_slot),
    .in_step         (in_chan.step),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_status      (out_chan.status),
    .out_slot_valid  (out_chan.slot_valid),
    .out_result_slot (out_chan.result_slot),
    .out_payload_out (out_chan.payload_out),
    .out_entry_count (out_chan.entry_count)
  );

endmodule
